// ----- src/assert_macros.svh -----
// Assertion macros used by the top-level RTL file. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, cond, msg)
`define ASSERT_IMPLY(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- src/tmaf_pkg.sv -----
package tmaf_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int COUNT_W    = 11;
    localparam int SUM_W      = 22;
    localparam int REF_W      = 18;
    localparam int DCOUNT_W   = 10;
    localparam int DIVISOR_W  = 22;
    localparam int PROD_W     = 40;
    localparam int QUOT_W     = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam logic [COUNT_W-1:0]  MAX_SAMPLES    = 11'd1024;
    localparam logic [COUNT_W-1:0]  MIN_COUNT      = 11'd3;
    localparam logic [COUNT_W-1:0]  TRIM_COUNT     = 11'd2;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE     = 12'hFFF;
    localparam logic [COUNT_W-1:0]  COUNT_RESET    = 11'd10;
    localparam logic [REF_W-1:0]    REFERENCE_RESET = 18'd216269;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE    = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_VSTART,
        ST_VWAIT,
        ST_RSTART,
        ST_RWAIT,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic short_count;
        logic burst_end;
    } accum_event_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ----- src/tmaf_accum.sv -----
module tmaf_accum (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             take,
    input  logic [tmaf_pkg::SAMPLE_W-1:0]    sample,
    input  logic [tmaf_pkg::COUNT_W-1:0]     sample_count,
    output tmaf_pkg::accum_event_t           ev,
    output logic [tmaf_pkg::SUM_W-1:0]       rem,
    output logic [tmaf_pkg::DCOUNT_W-1:0]    dcount
);

    logic [tmaf_pkg::COUNT_W-1:0]  index_reg, index_next;
    logic [tmaf_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [tmaf_pkg::SAMPLE_W-1:0] max_reg, max_next;
    logic [tmaf_pkg::SAMPLE_W-1:0] min_reg, min_next;
    logic [tmaf_pkg::SUM_W-1:0]    rem_reg, rem_next;
    logic [tmaf_pkg::DCOUNT_W-1:0] dcount_reg, dcount_next;
    logic [tmaf_pkg::COUNT_W-1:0]  n_lim;
    logic [tmaf_pkg::SUM_W-1:0]    sum_add;
    logic [tmaf_pkg::SAMPLE_W-1:0] max_new;
    logic [tmaf_pkg::SAMPLE_W-1:0] min_new;

    assign n_lim = (sample_count > tmaf_pkg::MAX_SAMPLES) ? tmaf_pkg::MAX_SAMPLES : sample_count;

    assign ev.short_count = (sample_count < tmaf_pkg::MIN_COUNT);
    assign ev.burst_end   = !ev.short_count && (index_reg != '0) && (index_reg >= n_lim);

    assign sum_add = sum_reg + tmaf_pkg::SUM_W'(sample);
    assign max_new = (sample > max_reg) ? sample : max_reg;
    assign min_new = (sample < min_reg) ? sample : min_reg;

    always_comb
    begin
        index_next  = index_reg;
        sum_next    = sum_reg;
        max_next    = max_reg;
        min_next    = min_reg;
        rem_next    = rem_reg;
        dcount_next = dcount_reg;
        if (take)
        begin
            if (ev.short_count)
            begin
                index_next = '0;
                sum_next   = '0;
                max_next   = '0;
                min_next   = tmaf_pkg::FULL_SCALE;
            end
            else if (index_reg == '0)
            begin
                // Settling conversion: counted but not summed.
                index_next = tmaf_pkg::COUNT_W'(1);
            end
            else if (ev.burst_end)
            begin
                rem_next    = sum_add - tmaf_pkg::SUM_W'(max_new) - tmaf_pkg::SUM_W'(min_new);
                dcount_next = tmaf_pkg::DCOUNT_W'(index_reg - tmaf_pkg::TRIM_COUNT);
                index_next  = '0;
                sum_next    = '0;
                max_next    = '0;
                min_next    = tmaf_pkg::FULL_SCALE;
            end
            else
            begin
                index_next = index_reg + tmaf_pkg::COUNT_W'(1);
                sum_next   = sum_add;
                max_next   = max_new;
                min_next   = min_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0;
            sum_reg   <= '0;
            max_reg   <= '0;
            min_reg   <= tmaf_pkg::FULL_SCALE;
        end
        else
        begin
            index_reg <= index_next;
            sum_reg   <= sum_next;
            max_reg   <= max_next;
            min_reg   <= min_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        dcount_reg <= dcount_next;
    end

    assign rem    = rem_reg;
    assign dcount = dcount_reg;

endmodule

// ----- src/tmaf_div.sv -----
module tmaf_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [tmaf_pkg::PROD_W-1:0]       dividend,
    input  logic [tmaf_pkg::DIVISOR_W-1:0]    divisor,
    output logic [tmaf_pkg::QUOT_W-1:0]       quotient,
    output tmaf_pkg::div_status_t             status
);

    localparam int CNT_W = $clog2(tmaf_pkg::QUOT_W + 1);

    logic [tmaf_pkg::DIVISOR_W-1:0] part_reg, part_next;
    logic [tmaf_pkg::QUOT_W-1:0]    quot_reg, quot_next;
    logic [tmaf_pkg::DIVISOR_W-1:0] divisor_reg, divisor_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [tmaf_pkg::DIVISOR_W:0]   trial;
    logic [tmaf_pkg::DIVISOR_W:0]   diff;
    logic                           fits;

    // One restoring shift-subtract step per cycle. The caller guarantees the
    // quotient fits in QUOT_W bits, so the top part starts below the divisor.
    assign trial = {part_reg, quot_reg[tmaf_pkg::QUOT_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = (trial >= {1'b0, divisor_reg});

    always_comb
    begin
        part_next    = part_reg;
        quot_next    = quot_reg;
        divisor_next = divisor_reg;
        count_next   = count_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (start && !busy_reg)
        begin
            part_next    = dividend[tmaf_pkg::PROD_W-1:tmaf_pkg::QUOT_W];
            quot_next    = dividend[tmaf_pkg::QUOT_W-1:0];
            divisor_next = divisor;
            count_next   = CNT_W'(tmaf_pkg::QUOT_W);
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            part_next  = fits ? diff[tmaf_pkg::DIVISOR_W-1:0] : trial[tmaf_pkg::DIVISOR_W-1:0];
            quot_next  = {quot_reg[tmaf_pkg::QUOT_W-2:0], fits};
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg    <= part_next;
        quot_reg    <= quot_next;
        divisor_reg <= divisor_next;
    end

    assign quotient    = quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ----- src/trimmed_mean_adc_filter_top.sv -----
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_ready    sample[11:0]
// output    out        out_valid/out_ready  voltage_q16[17:0], trimmed_mean_raw[11:0]
// config    in         cfg_valid/cfg_ready  cfg_index[1:0], cfg_data[17:0]
//
// While sample_count is three or more, a sample that does not close a burst leaves the
// input ready for the next sample. After the closing sample the input is held off through
// the multiply, two divider passes (start, 18 shift-subtract steps, done) and the write.
// With sample_count below three each sample yields a zero result through the write state,
// and the input pauses until that result is loaded into the output register.
// A result waiting in the output register holds back the next result, and the input
// stalls while that next result waits. Reset is asynchronous, active low, and restores
// the register defaults.
`include "assert_macros.svh"

module trimmed_mean_adc_filter_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [tmaf_pkg::SAMPLE_W-1:0]       sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tmaf_pkg::QUOT_W-1:0]         voltage_q16,
    output logic [tmaf_pkg::SAMPLE_W-1:0]       trimmed_mean_raw,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tmaf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tmaf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    tmaf_pkg::state_t state_reg, state_next;

    logic [tmaf_pkg::COUNT_W-1:0]   sample_count_reg;
    logic [tmaf_pkg::REF_W-1:0]     reference_q16_reg;
    logic [tmaf_pkg::PROD_W-1:0]    product_reg;
    logic [tmaf_pkg::QUOT_W-1:0]    volt_q_reg;
    logic [tmaf_pkg::SAMPLE_W-1:0]  raw_q_reg;
    logic                           out_valid_reg;
    logic [tmaf_pkg::QUOT_W-1:0]    voltage_q16_reg;
    logic [tmaf_pkg::SAMPLE_W-1:0]  trimmed_mean_raw_reg;

    logic                           take;
    tmaf_pkg::accum_event_t         ev;
    logic [tmaf_pkg::SUM_W-1:0]     rem;
    logic [tmaf_pkg::DCOUNT_W-1:0]  dcount;

    logic                           div_start;
    logic                           div_raw_sel;
    logic [tmaf_pkg::PROD_W-1:0]    div_dividend;
    logic [tmaf_pkg::DIVISOR_W-1:0] div_divisor;
    logic [tmaf_pkg::DIVISOR_W-1:0] dcount_fs;
    logic [tmaf_pkg::QUOT_W-1:0]    quotient;
    tmaf_pkg::div_status_t          div_st;

    logic                           mul_load;
    logic                           clear_q;
    logic                           load_volt;
    logic                           load_raw;
    logic                           out_load;
    logic                           slot_free;

    assign in_ready  = (state_reg == tmaf_pkg::ST_IDLE);
    assign take      = in_valid && in_ready;
    // Registers change only between items, never while one is being processed.
    assign cfg_ready = (state_reg == tmaf_pkg::ST_IDLE);
    assign slot_free = !out_valid_reg || out_ready;

    tmaf_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .sample       (sample),
        .sample_count (sample_count_reg),
        .ev           (ev),
        .rem          (rem),
        .dcount       (dcount)
    );

    // d * 4095 as a shift and subtract.
    assign dcount_fs = {dcount, tmaf_pkg::SAMPLE_W'(0)} - tmaf_pkg::DIVISOR_W'(dcount);

    assign div_dividend = div_raw_sel ? tmaf_pkg::PROD_W'(rem) : product_reg;
    assign div_divisor  = div_raw_sel ? tmaf_pkg::DIVISOR_W'(dcount) : dcount_fs;

    tmaf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quotient),
        .status   (div_st)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tmaf_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    priority if (ev.short_count)
                        state_next = tmaf_pkg::ST_WRITE;
                    else if (ev.burst_end)
                        state_next = tmaf_pkg::ST_MUL;
                    else
                        state_next = tmaf_pkg::ST_IDLE;
                end
            end
            tmaf_pkg::ST_MUL:    state_next = tmaf_pkg::ST_VSTART;
            tmaf_pkg::ST_VSTART: state_next = tmaf_pkg::ST_VWAIT;
            tmaf_pkg::ST_VWAIT:
            begin
                if (div_st.done)
                    state_next = tmaf_pkg::ST_RSTART;
            end
            tmaf_pkg::ST_RSTART: state_next = tmaf_pkg::ST_RWAIT;
            tmaf_pkg::ST_RWAIT:
            begin
                if (div_st.done)
                    state_next = tmaf_pkg::ST_WRITE;
            end
            tmaf_pkg::ST_WRITE:
            begin
                if (slot_free)
                    state_next = tmaf_pkg::ST_IDLE;
            end
            default: state_next = tmaf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        mul_load    = 1'b0;
        div_start   = 1'b0;
        div_raw_sel = 1'b0;
        clear_q     = 1'b0;
        load_volt   = 1'b0;
        load_raw    = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            tmaf_pkg::ST_IDLE:   clear_q = take && ev.short_count;
            tmaf_pkg::ST_MUL:    mul_load = 1'b1;
            tmaf_pkg::ST_VSTART: div_start = 1'b1;
            tmaf_pkg::ST_VWAIT:  load_volt = div_st.done;
            tmaf_pkg::ST_RSTART:
            begin
                div_start   = 1'b1;
                div_raw_sel = 1'b1;
            end
            tmaf_pkg::ST_RWAIT:  load_raw = div_st.done;
            tmaf_pkg::ST_WRITE:  out_load = slot_free;
            default:             clear_q = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= tmaf_pkg::ST_IDLE;
            sample_count_reg  <= tmaf_pkg::COUNT_RESET;
            reference_q16_reg <= tmaf_pkg::REFERENCE_RESET;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == tmaf_pkg::CFG_SAMPLE_COUNT)
                    sample_count_reg <= cfg_data[tmaf_pkg::COUNT_W-1:0];
                else if (cfg_index == tmaf_pkg::CFG_REFERENCE)
                    reference_q16_reg <= cfg_data[tmaf_pkg::REF_W-1:0];
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_load)
            product_reg <= tmaf_pkg::PROD_W'(rem) * tmaf_pkg::PROD_W'(reference_q16_reg);
        if (clear_q)
        begin
            volt_q_reg <= '0;
            raw_q_reg  <= '0;
        end
        if (load_volt)
            volt_q_reg <= quotient;
        if (load_raw)
            raw_q_reg <= quotient[tmaf_pkg::SAMPLE_W-1:0];
        if (out_load)
        begin
            voltage_q16_reg      <= volt_q_reg;
            trimmed_mean_raw_reg <= raw_q_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign voltage_q16      = voltage_q16_reg;
    assign trimmed_mean_raw = trimmed_mean_raw_reg;

    `ASSERT_IMPLY(a_ready_div_idle, in_ready, !div_st.busy, "input ready while divider busy")
    `ASSERT_NEXT(a_vdone_to_raw, (state_reg == tmaf_pkg::ST_VWAIT) && div_st.done, state_reg == tmaf_pkg::ST_RSTART, "voltage pass did not hand over to count pass")
    `ASSERT_IMPLY(a_raw_range, (state_reg == tmaf_pkg::ST_RWAIT) && div_st.done, quotient[tmaf_pkg::QUOT_W-1:tmaf_pkg::SAMPLE_W] == '0, "count quotient exceeds full scale")
    `ASSERT_IMPLY(a_volt_range, (state_reg == tmaf_pkg::ST_VWAIT) && div_st.done, quotient <= reference_q16_reg, "voltage quotient exceeds reference")

endmodule
